### design/mdfs_pkg.sv
package mdfs_pkg;

  // Field and register widths
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PIX_W      = 3 * CHAN_W;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned SIDE_W     = 9;
  localparam int unsigned TOL_W      = 10;
  localparam int unsigned DIST_W     = 10;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Mean division: one quotient bit per step over the whole sum
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [SIDE_W-1:0] SIDE_MAX   = 9'd256;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 9'd1;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;
  localparam logic [TOL_W-1:0]  TOL_RESET  = 10'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_TOLERANCE    = 2'd2
  } cfg_idx_e;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // store pixel, update sums and count
    logic restart;    // load discards the frame being read out
    logic div_start;  // load the dividers with the new sums
    logic div_step;   // one quotient bit
    logic fetch;      // read store at the read position
    logic emit;       // fill the output register
    logic emit_ok;    // emitted transaction is a real classification
    logic advance;    // step the read position
    logic clear;      // end of read-out, clear the frame
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_done; // the pixel being loaded completes the frame
    logic div_last;   // final division step
    logic last_pix;   // read position is the last pixel of the frame
  } sts_t;

endpackage

### design/mdfs_ram.sv
module mdfs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mdfs_div_lane.sv
module mdfs_div_lane #(
  parameter int unsigned DIVISOR_W = 17
) (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [mdfs_pkg::SUM_W-1:0]  dividend_i,
  input  logic [DIVISOR_W-1:0]        divisor_i,
  output logic [mdfs_pkg::CHAN_W-1:0] quotient_o
);

  // Restoring division, MSB first. Remainder stays below the divisor.
  logic [DIVISOR_W-1:0]       rem_q, rem_d;
  logic [mdfs_pkg::SUM_W-1:0] quo_q;
  logic [DIVISOR_W:0]         trial;
  logic [DIVISOR_W:0]         diff;
  logic                       fits;

  assign trial = {rem_q, quo_q[mdfs_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  assign rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[mdfs_pkg::SUM_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q[mdfs_pkg::CHAN_W-1:0];

endmodule

### design/mdfs_ctrl.sv
module mdfs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           kind_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  input  mdfs_pkg::sts_t sts_i,
  output mdfs_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_FETCH  = 3'b010,
    ST_DIVIDE = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic           phase_q, phase_d;      // 1 while a frame is being read out
  logic           fetch_ok_q, fetch_ok_d;
  logic           out_valid_q, out_valid_d;
  logic           accept;
  mdfs_pkg::cmd_t cmd;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fetch_ok_d = fetch_ok_q;
    cmd        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == mdfs_pkg::KIND_LOAD) begin
            cmd.load    = 1'b1;
            cmd.restart = phase_q;
            phase_d     = 1'b0;
            if (sts_i.frame_done) begin
              cmd.div_start = 1'b1;
              state_d       = ST_DIVIDE;
            end
          end else begin
            cmd.fetch  = 1'b1;
            fetch_ok_d = phase_q;
            state_d    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        // wait here until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd.emit    = 1'b1;
          cmd.emit_ok = fetch_ok_q;
          if (fetch_ok_q) begin
            if (sts_i.last_pix) begin
              cmd.clear = 1'b1;
              phase_d   = 1'b0;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          phase_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd.emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      fetch_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fetch_ok_q  <= fetch_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

### design/mdfs_datapath.sv
module mdfs_datapath #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mdfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mdfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [mdfs_pkg::CHAN_W-1:0]     red_i,
  input  logic [mdfs_pkg::CHAN_W-1:0]     green_i,
  input  logic [mdfs_pkg::CHAN_W-1:0]     blue_i,
  input  mdfs_pkg::cmd_t                  cmd_i,
  output mdfs_pkg::sts_t                  sts_o,
  output logic                            foreground_o,
  output logic [mdfs_pkg::IDX_W-1:0]      pixel_index_o,
  output logic                            last_of_frame_o,
  output logic                            status_o
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SW = mdfs_pkg::SIDE_W;
  localparam int unsigned CH = mdfs_pkg::CHAN_W;

  function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    if (v < mdfs_pkg::SIDE_MIN) begin
      r = mdfs_pkg::SIDE_MIN;
    end else if (v > mdfs_pkg::SIDE_MAX) begin
      r = mdfs_pkg::SIDE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CH-1:0] abs_diff(input logic [CH-1:0] a, input logic [CH-1:0] b);
    logic [CH-1:0] r;
    r = (a >= b) ? (a - b) : (b - a);
    return r;
  endfunction

  // Configuration
  logic [SW-1:0]                  width_q, height_q;
  logic [mdfs_pkg::TOL_W-1:0]     tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mdfs_pkg::SIDE_RESET;
      height_q <= mdfs_pkg::SIDE_RESET;
      tol_q    <= mdfs_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mdfs_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[SW-1:0];
        mdfs_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i[SW-1:0];
        mdfs_pkg::CFG_TOLERANCE:    tol_q    <= cfg_data_i[mdfs_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size, limited to the store depth
  logic [2*SW-1:0] frame_prod;
  logic [31:0]     prod_ext;
  logic [31:0]     frame_size;

  assign frame_prod = (2*SW)'(clamp_side(width_q)) * (2*SW)'(clamp_side(height_q));
  assign prod_ext   = 32'(frame_prod);
  assign frame_size = (prod_ext > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS) : prod_ext;

  // Frame accumulation
  logic [CW-1:0]              count_q;
  logic [CW-1:0]              base_count, new_count;
  logic [mdfs_pkg::SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [mdfs_pkg::SUM_W-1:0] sum_r_d, sum_g_d, sum_b_d;
  logic [AW-1:0]              rd_pos_q;
  logic [mdfs_pkg::DIV_CNT_W-1:0] div_cnt_q;

  assign base_count = cmd_i.restart ? '0 : count_q;
  assign new_count  = base_count + CW'(1);
  assign sum_r_d = (cmd_i.restart ? '0 : sum_r_q) + mdfs_pkg::SUM_W'(red_i);
  assign sum_g_d = (cmd_i.restart ? '0 : sum_g_q) + mdfs_pkg::SUM_W'(green_i);
  assign sum_b_d = (cmd_i.restart ? '0 : sum_b_q) + mdfs_pkg::SUM_W'(blue_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_r_q  <= '0;
      sum_g_q  <= '0;
      sum_b_q  <= '0;
      rd_pos_q <= '0;
    end else if (cmd_i.clear) begin
      count_q  <= '0;
      sum_r_q  <= '0;
      sum_g_q  <= '0;
      sum_b_q  <= '0;
      rd_pos_q <= '0;
    end else if (cmd_i.load) begin
      count_q  <= new_count;
      sum_r_q  <= sum_r_d;
      sum_g_q  <= sum_g_d;
      sum_b_q  <= sum_b_d;
      rd_pos_q <= '0;
    end else if (cmd_i.advance) begin
      rd_pos_q <= rd_pos_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + mdfs_pkg::DIV_CNT_W'(1);
    end
  end

  // Pixel store
  logic [mdfs_pkg::PIX_W-1:0] pix;

  mdfs_ram #(
    .WIDTH(mdfs_pkg::PIX_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (base_count[AW-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (cmd_i.fetch),
    .raddr_i (rd_pos_q),
    .rdata_o (pix)
  );

  // Per-channel mean, quotient held in the dividers until the next frame
  logic [CH-1:0] mean_r, mean_g, mean_b;

  mdfs_div_lane #(.DIVISOR_W(CW)) u_div_r (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (sum_r_d),
    .divisor_i  (count_q),
    .quotient_o (mean_r)
  );

  mdfs_div_lane #(.DIVISOR_W(CW)) u_div_g (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (sum_g_d),
    .divisor_i  (count_q),
    .quotient_o (mean_g)
  );

  mdfs_div_lane #(.DIVISOR_W(CW)) u_div_b (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (sum_b_d),
    .divisor_i  (count_q),
    .quotient_o (mean_b)
  );

  // Classification
  logic [mdfs_pkg::DIST_W-1:0] l1_dist;
  logic [31:0]                 pos_ext;
  logic                        last_pix;

  assign l1_dist = mdfs_pkg::DIST_W'(abs_diff(pix[3*CH-1:2*CH], mean_r))
                 + mdfs_pkg::DIST_W'(abs_diff(pix[2*CH-1:CH], mean_g))
                 + mdfs_pkg::DIST_W'(abs_diff(pix[CH-1:0], mean_b));
  assign pos_ext  = 32'(rd_pos_q);
  assign last_pix = (pos_ext + 32'd1) == 32'(count_q);

  logic                       fg_q, last_q, status_q;
  logic [mdfs_pkg::IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fg_q     <= cmd_i.emit_ok && (l1_dist >= tol_q);
      idx_q    <= cmd_i.emit_ok ? pos_ext[mdfs_pkg::IDX_W-1:0] : '0;
      last_q   <= cmd_i.emit_ok && last_pix;
      status_q <= cmd_i.emit_ok ? mdfs_pkg::STATUS_OK : mdfs_pkg::STATUS_NOT_READY;
    end
  end

  assign sts_o.frame_done = 32'(new_count) >= frame_size;
  assign sts_o.div_last   = div_cnt_q == mdfs_pkg::DIV_CNT_W'(mdfs_pkg::DIV_STEPS - 1);
  assign sts_o.last_pix   = last_pix;

  assign foreground_o    = fg_q;
  assign pixel_index_o   = idx_q;
  assign last_of_frame_o = last_q;
  assign status_o        = status_q;

endmodule

### design/mean_distance_frame_segmenter_core.sv
// Load transactions: one per cycle while the input is not stalled, no result.
// Fetch transactions: the store is read, then the output register is filled; the input is stalled
//   between the two and for as long as the output is stalled before the fill.
// The load that completes a frame stalls the input while three restoring
//   dividers produce the channel means one quotient bit per cycle.
// Reset (rst_ni, async, active low) clears control, counts, sums and config; store kept.
module mean_distance_frame_segmenter_core #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mdfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mdfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [mdfs_pkg::CHAN_W-1:0]     red_i,
  input  logic [mdfs_pkg::CHAN_W-1:0]     green_i,
  input  logic [mdfs_pkg::CHAN_W-1:0]     blue_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            foreground_o,
  output logic [mdfs_pkg::IDX_W-1:0]      pixel_index_o,
  output logic                            last_of_frame_o,
  output logic                            status_o
);

  mdfs_pkg::cmd_t cmd;
  mdfs_pkg::sts_t sts;

  // Registers are always writable; they are meant to change only while the block is idle.
  assign cfg_ready_o = 1'b1;

  // Controller: idle / fetch / divide sequencing, read-out phase flag and
  // output valid. Loads are absorbed in the idle state; a fetch parks in
  // the fetch state until the output register is free and stalls the input
  // meanwhile. Loads behind a waiting result still go through.
  mdfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: configuration, frame size, per-channel sums, pixel store,
  // mean dividers, L1 distance and the output payload register.
  mdfs_datapath #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .foreground_o    (foreground_o),
    .pixel_index_o   (pixel_index_o),
    .last_of_frame_o (last_of_frame_o),
    .status_o        (status_o)
  );

`ifndef SYNTHESIS
  // A not-ready answer carries no classification.
  a_not_ready_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mdfs_pkg::STATUS_NOT_READY)
      |-> !foreground_o && (pixel_index_o == '0) && !last_of_frame_o)
    else $error("not-ready result with non-zero fields");

  // An accepted fetch always stalls the input in the following cycle.
  a_fetch_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == mdfs_pkg::KIND_FETCH) |=> in_stall_o)
    else $error("input taken during store read");

  // No transaction is taken while the means are being divided.
  a_div_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> in_stall_o)
    else $error("input taken during mean division");

  // Store writes only happen on an accepted load.
  a_load_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> in_valid_i && !in_stall_o && (kind_i == mdfs_pkg::KIND_LOAD))
    else $error("load without accepted transaction");
`endif

endmodule
